// ===== design/esd_pkg.sv =====
package esd_pkg;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_CHAR  = 3'd1,
		ST_BAD_ESC   = 3'd2,
		ST_OCT_COUNT = 3'd3,
		ST_BAD_OCT   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		PH_NORMAL = 3'd0,
		PH_ESC    = 3'd1,
		PH_OCT1   = 3'd2,
		PH_OCT2   = 3'd3,
		PH_CHECK  = 3'd4
	} phase_t;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	typedef struct packed {
		logic [7:0] char_in;
		logic       quoted;
		logic       last;
	} item_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] char_out;
		logic       char_valid;
		logic       done;
		status_t    status;
	} res_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic plain_ok(input logic [7:0] c);
		logic intl;
		case (c)
			8'h83, 8'h8A, 8'h8C, 8'h8E, 8'h9A, 8'h9C, 8'h9E, 8'h9F,
			8'hAA, 8'hB2, 8'hB3, 8'hB9, 8'hBA: intl = 1'b1;
			default: intl = ((c >= 8'hC0) && (c <= 8'hD6)) || ((c >= 8'hD8) && (c <= 8'hF6))
				|| (c >= 8'hF8);
		endcase
		return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A))
			|| intl;
	endfunction

	function automatic logic quoted_ok(input logic [7:0] c);
		return (c != 8'h00) && (c != 8'h81) && (c != 8'h8D) && (c != 8'h8F)
			&& (c != 8'h90) && (c != 8'h9D);
	endfunction

endpackage

// ===== design/esd_core.sv =====
module esd_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  esd_pkg::item_t item,
	output esd_pkg::res_t  res
);

	logic               in_string_q;
	logic               quoted_mode_q;
	esd_pkg::phase_t    phase_q;
	logic [8:0]         oval_q;
	logic               obad_q;
	esd_pkg::status_t   ferr_q;

	logic               qm;
	esd_pkg::phase_t    ph;
	logic [8:0]         ov;
	logic               ob;
	esd_pkg::status_t   fe;
	esd_pkg::status_t   err;
	logic               emit;
	logic [7:0]         ch;
	logic [8:0]         ov_sum;
	logic [7:0]         c;

	assign c = item.char_in;
	assign ov_sum = {oval_q[5:0], 3'b000} + {5'd0, c[3:0]};

	always_comb begin
		qm   = in_string_q ? quoted_mode_q : item.quoted;
		ph   = in_string_q ? phase_q : esd_pkg::PH_NORMAL;
		ov   = in_string_q ? oval_q : 9'd0;
		ob   = in_string_q ? obad_q : 1'b0;
		fe   = in_string_q ? ferr_q : esd_pkg::ST_OK;
		err  = esd_pkg::ST_OK;
		emit = 1'b0;
		ch   = 8'd0;
		if (fe == esd_pkg::ST_OK) begin
			if (!qm) begin
				if (esd_pkg::plain_ok(c)) begin
					emit = 1'b1;
					ch   = c;
				end else begin
					err = esd_pkg::ST_BAD_CHAR;
				end
			end else begin
				if (ph == esd_pkg::PH_CHECK) begin
					if (esd_pkg::is_digit(c)) err = esd_pkg::ST_OCT_COUNT;
					else if (ob) err = esd_pkg::ST_BAD_OCT;
					else ph = esd_pkg::PH_NORMAL;
				end
				if (err == esd_pkg::ST_OK) begin
					case (ph)
						esd_pkg::PH_NORMAL: begin
							if (c == esd_pkg::CH_BSLASH) begin
								if (item.last) err = esd_pkg::ST_BAD_ESC;
								else ph = esd_pkg::PH_ESC;
							end else if (esd_pkg::quoted_ok(c)) begin
								emit = 1'b1;
								ch   = c;
							end else begin
								err = esd_pkg::ST_BAD_CHAR;
							end
						end
						esd_pkg::PH_ESC: begin
							if (esd_pkg::is_digit(c)) begin
								ob = c[3];
								ov = {5'd0, c[3:0]};
								ph = esd_pkg::PH_OCT1;
								if (item.last) err = esd_pkg::ST_OCT_COUNT;
							end else begin
								ph = esd_pkg::PH_NORMAL;
								case (c)
									esd_pkg::CH_N: begin
										ch = esd_pkg::CH_LF;
										emit = 1'b1;
									end
									esd_pkg::CH_T: begin
										ch = esd_pkg::CH_TAB;
										emit = 1'b1;
									end
									esd_pkg::CH_R: begin
										ch = esd_pkg::CH_CR;
										emit = 1'b1;
									end
									esd_pkg::CH_BSLASH, esd_pkg::CH_SQUOTE,
									esd_pkg::CH_DQUOTE: begin
										ch = c;
										emit = 1'b1;
									end
									default: err = esd_pkg::ST_BAD_ESC;
								endcase
							end
						end
						esd_pkg::PH_OCT1: begin
							if (esd_pkg::is_digit(c)) begin
								ob = ob | c[3];
								ov = ov_sum;
								ph = esd_pkg::PH_OCT2;
								if (item.last) err = esd_pkg::ST_OCT_COUNT;
							end else begin
								err = esd_pkg::ST_OCT_COUNT;
							end
						end
						esd_pkg::PH_OCT2: begin
							if (esd_pkg::is_digit(c)) begin
								ob = ob | c[3];
								ov = ov_sum;
								if (ob || ov[8] || (ov == 9'd0) || !esd_pkg::quoted_ok(ov[7:0]))
								begin
									ob = 1'b1;
									if (item.last) err = esd_pkg::ST_BAD_OCT;
								end else begin
									emit = 1'b1;
									ch   = ov[7:0];
								end
								ph = esd_pkg::PH_CHECK;
							end else begin
								err = esd_pkg::ST_OCT_COUNT;
							end
						end
						default: ph = esd_pkg::PH_NORMAL;
					endcase
				end
			end
			if (err != esd_pkg::ST_OK) fe = err;
		end

		res.valid      = emit | item.last;
		res.char_out   = ch;
		res.char_valid = emit;
		res.done       = item.last;
		res.status     = item.last ? fe : esd_pkg::ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_string_q   <= 1'b0;
			quoted_mode_q <= 1'b0;
			phase_q       <= esd_pkg::PH_NORMAL;
			oval_q        <= 9'd0;
			obad_q        <= 1'b0;
			ferr_q        <= esd_pkg::ST_OK;
		end else if (fire) begin
			in_string_q   <= !item.last;
			quoted_mode_q <= qm;
			ferr_q        <= fe;
			if (item.last) begin
				phase_q <= esd_pkg::PH_NORMAL;
				oval_q  <= 9'd0;
				obad_q  <= 1'b0;
			end else begin
				phase_q <= ph;
				oval_q  <= ov;
				obad_q  <= ob;
			end
		end
	end

endmodule

// ===== design/escape_sequence_decoder_unit.sv =====
// channel  dir  tdata                                tuser          tlast
// s_axis   in   [7:0] char_in                        [0] quoted     last
// m_axis   out  [7:0] char_out, [10:8] status        [0] char_valid done_res
//
// One byte per cycle sustained while the output is not stalled. A transfer is
// registered at the input, decoded against the string state and lands in the
// output register. Bytes that give no result (escape prefix, leading octal
// digits, dropped bytes) leave no output.
// Reset clears string state and both valid flags. A stalled output holds the
// input stage, and s_axis_tready falls only when both registers are full.
module escape_sequence_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
	input  logic [0:0]  s_axis_tuser,   // [0] quoted
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] char_out, [10:8] status, rest zero
	output logic [0:0]  m_axis_tuser,   // [0] char_valid
	output logic        m_axis_tlast
);

	logic           valid_s1;
	esd_pkg::item_t item_s1;
	esd_pkg::res_t  res;
	logic           out_free;
	logic           advance;
	logic           s_fire;

	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_fire || (valid_s1 && !out_free);
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			item_s1.char_in <= s_axis_tdata;
			item_s1.quoted  <= s_axis_tuser[0];
			item_s1.last    <= s_axis_tlast;
		end
	end

	esd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_free) begin
			m_axis_tvalid <= valid_s1 && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			m_axis_tdata <= {5'd0, res.status, res.char_out};
			m_axis_tuser <= res.char_valid;
			m_axis_tlast <= res.done;
		end
	end

endmodule

// ===== design/esd_checker.sv =====
module esd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output changed while stalled");

	a_has_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser[0] || m_axis_tlast)
		else $error("empty result transfer");

	a_status_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[10:8] == esd_pkg::ST_OK)
		else $error("status outside final transfer");

	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'd0)
		else $error("char_out set without char_valid");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[10:8] <= esd_pkg::ST_BAD_OCT
		&& m_axis_tdata[15:11] == 5'd0)
		else $error("status code out of range");

endmodule

bind escape_sequence_decoder_unit esd_checker u_esd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
